// ===== sv/pprp_pkg.sv =====
package pprp_pkg;

	localparam int MAX_PERIOD_FRAMES = 1024;
	localparam int DESCRIPTOR_SLOTS  = 32;
	localparam int SLOT_W            = $clog2(DESCRIPTOR_SLOTS);
	localparam int FPP_W             = 11;
	localparam int RING_W            = 15;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FORMAT    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FPP       = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PERIODS   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd4;

	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_SEAL = 2'd1;
	localparam logic [1:0] OP_KICK = 2'd2;
	localparam logic [1:0] OP_DROP = 2'd3;

	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 80;

	typedef struct packed {
		logic [1:0]              kind;
		logic [RING_W-1:0]       ring_frame;
		logic signed [15:0]      left_sample;
		logic signed [15:0]      right_sample;
		logic [SLOT_W-1:0]       slot_index;
		logic [FPP_W-1:0]        silence_from;
		logic [FPP_W-1:0]        silence_count;
		logic                    start_engine;
		logic                    last_result;
	} result_t;

endpackage

// ===== sv/pcm_period_ring_packer.sv =====
// PCM period ring packer. Raw PCM bytes (U8 or S16LE, mono or stereo) enter one transaction
// per cycle on the s_ side, with the opcode in s_tuser. Each completed frame leaves as a stereo
// S16 frame write; a full period, a sealed or kicked tail or a padding period leaves as a commit to
// the next descriptor slot. An input transaction gives zero, one or two results, which queue in a
// four-entry result buffer. The block takes one input per cycle while that buffer has room for
// two results, so the sustained rate is one byte per cycle as long as the m_ side drains one
// result per cycle; an item that yields two results needs two output transfers. An accepted input
// is held in the input register, and its results are then written into the result buffer. Writes
// to channel count, sample format, frames per period or periods in ring clear the stream, as a
// drop does; the configuration port is meant to be written only while the block is idle.
module pcm_period_ring_packer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pprp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [pprp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pprp_pkg::IN_DATA_W-1:0]       s_tdata,   // data_byte, engine_slot
	input  logic [1:0]                           s_tuser,   // opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// ring_frame, left_sample, right_sample, slot_index, silence_from, silence_count,
	// start_engine
	output logic [pprp_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser,   // kind
	output logic                                 m_tlast    // last_result
);
	import pprp_pkg::*;

	// configuration
	logic [1:0]            chan_q;
	logic                  fmt_q;
	logic [FPP_W-1:0]      fpp_q;
	logic [SLOT_W-1:0]     pir_q;
	logic [23:0]           thr_q;

	// stream state
	logic [23:0]           carry_q;
	logic [1:0]            carry_cnt_q;
	logic [FPP_W-1:0]      asm_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     rp_q;
	logic [47:0]           staged_q;
	logic                  run_q;

	// input register
	logic                  valid_s1;
	logic [1:0]            op_s1;
	logic [7:0]            byte_s1;
	logic [SLOT_W-1:0]     eslot_s1;

	// result buffer
	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	logic                  proc;
	logic                  rd;
	logic [FPP_W-1:0]      f_eff;
	logic [SLOT_W-1:0]     p_eff;
	logic [SLOT_W-1:0]     outst;
	logic                  full;
	logic [15:0]           prod;
	logic [RING_W-1:0]     base;
	logic [RING_W-1:0]     base_nx;
	logic [SLOT_W-1:0]     rp_inc;
	logic [SLOT_W-1:0]     rp_nx;
	logic [SLOT_W-1:0]     rp_inc2;
	logic [SLOT_W-1:0]     rp_nx2;
	logic [47:0]           thr48;
	logic [47:0]           staged1;
	logic [47:0]           staged2;
	logic                  stereo;
	logic                  wide;
	logic [1:0]            last_idx;
	logic                  frame_done;
	logic [31:0]           word;
	logic [15:0]           lsamp;
	logic [15:0]           rsamp;
	logic [FPP_W-1:0]      asm_inc;
	logic                  is_data;
	logic                  is_seal;
	logic                  is_kick;
	logic                  is_sk;
	logic                  c1;
	logic                  c2;
	logic                  start1;
	logic                  start2;
	logic                  run_a;
	logic                  run_b;
	logic                  pend;
	logic                  late;
	logic [SLOT_W-1:0]     slot_a;
	logic [SLOT_W-1:0]     slot_b;
	logic [SLOT_W-1:0]     rp_a;
	logic [SLOT_W-1:0]     rp_b;
	logic [SLOT_W-1:0]     out_a;
	logic [RING_W-1:0]     base_a;
	logic [47:0]           staged_a;
	logic [47:0]           staged_a1;
	logic [47:0]           staged_b;
	logic [FPP_W-1:0]      sfrom1;
	logic [FPP_W-1:0]      scnt1;
	result_t               res_frame;
	result_t               res_c1;
	result_t               res_c2;
	result_t               res_rej;
	result_t               res0;
	result_t               res1;
	logic [1:0]            nres;
	result_t               head;

	assign rd       = m_tvalid && m_tready;
	assign proc     = valid_s1 && (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || proc;

	always_comb begin
		f_eff = (fpp_q == '0 || fpp_q > FPP_W'(MAX_PERIOD_FRAMES)) ?
			FPP_W'(MAX_PERIOD_FRAMES) : fpp_q;
		p_eff = (pir_q == '0) ? SLOT_W'(DESCRIPTOR_SLOTS - 1) : pir_q;
		outst = slot_q - eslot_s1;
		full  = outst >= SLOT_W'(DESCRIPTOR_SLOTS - 1);

		prod    = 16'(rp_q) * 16'(f_eff);
		base    = prod[RING_W-1:0];
		rp_inc  = rp_q + 1'b1;
		rp_nx   = (rp_inc == p_eff) ? '0 : rp_inc;
		rp_inc2 = rp_nx + 1'b1;
		rp_nx2  = (rp_inc2 == p_eff) ? '0 : rp_inc2;
		base_nx = (rp_nx == '0) ? '0 : base + RING_W'(f_eff);

		thr48   = {24'd0, thr_q};
		staged1 = staged_q + 48'(f_eff);
		staged2 = staged_q + 48'({f_eff, 1'b0});

		stereo     = chan_q != 2'd1;
		wide       = fmt_q;
		last_idx   = (stereo && wide) ? 2'd3 : ((stereo || wide) ? 2'd1 : 2'd0);
		frame_done = carry_cnt_q == last_idx;
		word       = {8'd0, carry_q} | ({24'd0, byte_s1} << {carry_cnt_q, 3'b000});
		if (wide) begin
			lsamp = word[15:0];
			rsamp = stereo ? word[31:16] : word[15:0];
		end else begin
			lsamp = {word[7:0] ^ 8'h80, 8'h00};
			rsamp = stereo ? {word[15:8] ^ 8'h80, 8'h00} : {word[7:0] ^ 8'h80, 8'h00};
		end
		asm_inc = asm_q + 1'b1;

		is_data = op_s1 == OP_DATA;
		is_seal = op_s1 == OP_SEAL;
		is_kick = op_s1 == OP_KICK;
		is_sk   = is_seal || is_kick;

		c1 = (is_data && !full && frame_done && asm_inc == f_eff)
			|| (is_seal && asm_q != '0 && !full)
			|| (is_kick && !run_q && outst == '0 && asm_q != '0);
		sfrom1 = is_data ? f_eff : asm_q;
		scnt1  = is_data ? '0 : f_eff - asm_q;

		start1    = !run_q && staged1 >= thr48;
		run_a     = c1 ? (run_q || start1) : run_q;
		slot_a    = c1 ? slot_q + 1'b1 : slot_q;
		rp_a      = c1 ? rp_nx : rp_q;
		out_a     = c1 ? outst + 1'b1 : outst;
		base_a    = c1 ? base_nx : base;
		staged_a  = c1 ? staged1 : staged_q;
		staged_a1 = c1 ? staged2 : staged1;

		// padding period when the engine would start on a single slot
		pend   = is_sk && !run_a && out_a != '0;
		c2     = pend && out_a == SLOT_W'(1) && p_eff >= SLOT_W'(2);
		start2 = !run_a && staged_a1 >= thr48;
		run_b  = c2 ? (run_a || start2) : run_a;
		late   = pend && !run_b;
		slot_b   = c2 ? slot_a + 1'b1 : slot_a;
		rp_b     = c2 ? (c1 ? rp_nx2 : rp_nx) : rp_a;
		staged_b = c2 ? staged_a1 : staged_a;

		res_rej      = '0;
		res_rej.kind = KIND_REJECT;

		res_frame              = '0;
		res_frame.kind         = KIND_FRAME;
		res_frame.ring_frame   = base + RING_W'(asm_q);
		res_frame.left_sample  = lsamp;
		res_frame.right_sample = rsamp;

		res_c1               = '0;
		res_c1.kind          = KIND_COMMIT;
		res_c1.ring_frame    = base;
		res_c1.slot_index    = slot_q;
		res_c1.silence_from  = sfrom1;
		res_c1.silence_count = scnt1;
		res_c1.start_engine  = start1 || (late && !c2);

		res_c2               = '0;
		res_c2.kind          = KIND_COMMIT;
		res_c2.ring_frame    = base_a;
		res_c2.slot_index    = slot_a;
		res_c2.silence_count = f_eff;
		res_c2.start_engine  = (start2 && !run_a) || late;

		res0 = res_c1;
		res1 = res_c2;
		nres = 2'd0;
		if (is_data) begin
			if (full) begin
				res0 = res_rej;
				nres = 2'd1;
			end else if (frame_done) begin
				res0 = res_frame;
				res1 = res_c1;
				nres = c1 ? 2'd2 : 2'd1;
			end
		end else if (is_sk) begin
			if (c1) begin
				nres = c2 ? 2'd2 : 2'd1;
			end else if (c2) begin
				res0 = res_c2;
				nres = 2'd1;
			end
		end
		res0.last_result = nres == 2'd1;
		res1.last_result = 1'b1;
		if (!proc) begin
			nres = 2'd0;
		end

		head = fifo_q[rd_ptr_q];
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last_result;
	assign m_tdata  = {5'd0, head.start_engine, head.silence_count, head.silence_from,
		head.slot_index, head.right_sample, head.left_sample, head.ring_frame};

	always_ff @(posedge clk) begin
		if (nres != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (nres == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(nres);
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(nres) - FIFO_CNT_W'(rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			byte_s1  <= s_tdata[7:0];
			eslot_s1 <= s_tdata[8 +: SLOT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= 2'd2;
			fmt_q       <= 1'b1;
			fpp_q       <= FPP_W'(MAX_PERIOD_FRAMES);
			pir_q       <= SLOT_W'(DESCRIPTOR_SLOTS - 1);
			thr_q       <= 24'd1;
			carry_q     <= '0;
			carry_cnt_q <= '0;
			asm_q       <= '0;
			slot_q      <= '0;
			rp_q        <= '0;
			staged_q    <= '0;
			run_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CHANNELS:  chan_q <= cfg_wdata[1:0];
				REG_FORMAT:    fmt_q  <= cfg_wdata[0];
				REG_FPP:       fpp_q  <= cfg_wdata[FPP_W-1:0];
				REG_PERIODS:   pir_q  <= cfg_wdata[SLOT_W-1:0];
				REG_THRESHOLD: thr_q  <= cfg_wdata[23:0];
				default: ;
			endcase
			if (cfg_addr == REG_CHANNELS || cfg_addr == REG_FORMAT
					|| cfg_addr == REG_FPP || cfg_addr == REG_PERIODS) begin
				carry_q     <= '0;
				carry_cnt_q <= '0;
				asm_q       <= '0;
				slot_q      <= '0;
				rp_q        <= '0;
				staged_q    <= '0;
				run_q       <= 1'b0;
			end
		end else if (proc) begin
			if (op_s1 == OP_DROP) begin
				carry_q     <= '0;
				carry_cnt_q <= '0;
				asm_q       <= '0;
				slot_q      <= '0;
				rp_q        <= '0;
				staged_q    <= '0;
				run_q       <= 1'b0;
			end else begin
				if (is_data) begin
					if (!full) begin
						if (frame_done) begin
							carry_q     <= '0;
							carry_cnt_q <= '0;
							asm_q       <= c1 ? '0 : asm_inc;
						end else begin
							carry_q     <= word[23:0];
							carry_cnt_q <= carry_cnt_q + 1'b1;
						end
					end
				end else begin
					if (is_seal) begin
						carry_q     <= '0;
						carry_cnt_q <= '0;
					end
					if (c1) begin
						asm_q <= '0;
					end
				end
				slot_q   <= slot_b;
				rp_q     <= rp_b;
				staged_q <= staged_b;
				run_q    <= run_b || late;
			end
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result buffer overrun");

	a_asm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		asm_q < f_eff)
		else $error("assembled frames reached the period length");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q < p_eff)
		else $error("ring period beyond ring size");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_data && full && !cfg_we |=>
			$stable(carry_q) && $stable(carry_cnt_q) && $stable(asm_q) && $stable(slot_q))
		else $error("rejected byte altered stream state");

	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && op_s1 == OP_DROP |=> !run_q && slot_q == '0 && asm_q == '0)
		else $error("drop left stream state behind");

endmodule
